// ===== design/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared widths and constants of the frame budget controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

    localparam int PHASES  = 6;
    localparam int IDX_W   = 3;
    localparam int DUR_W   = 20;
    localparam int DEF_W   = 16;
    localparam int W_W     = 24;
    localparam int SUMW_W  = 27;
    localparam int TOT_W   = 23;
    localparam int DEFT_W  = 19;
    localparam int USED_W  = 20;
    localparam int TGT_W   = 17;
    localparam int STEP_W  = 16;
    localparam int LIM_W   = 16;
    localparam int BOOST_W = 26;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;

    // shared divider: dividend and divisor widths
    localparam int DIV_DW = 50;
    localparam int DIV_VW = 24;

    // shared multiplier operand widths
    localparam int MUL_AW = 27;
    localparam int MUL_BW = 24;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [W_W-1:0]     WEIGHT_FLOOR = 24'd6554;
    localparam logic [W_W-1:0]     WEIGHT_MAX   = 24'hFFFFFF;
    localparam logic [BOOST_W-1:0] BOOST_MAX    = 26'd42949673;
    localparam logic [BOOST_W-1:0] BOOST_MIN    = 26'd42950;
    localparam logic [USED_W-1:0]  USED_MAX     = 20'hFFFFF;
    localparam logic [SUMW_W-1:0]  SUMW_MIN     = 27'd656;
    localparam logic [TOT_W-1:0]   TOT_MIN      = 23'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PP_UP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_UP = 3'd5;

endpackage

`default_nettype wire

// ===== design/fbc_mul.sv =====
// ----------------------------------------------------------------------------
// fbc_mul
// Shared multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_mul
    import fbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MUL_AW-1:0] a,
    input  wire logic [MUL_BW-1:0] b,
    output logic      [MUL_PW-1:0] p
);

    logic [MUL_PW-1:0] p_reg;

    // product lands in the cycle after the operands
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_PW'(a) * MUL_PW'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== design/fbc_div.sv =====
// ----------------------------------------------------------------------------
// fbc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_div
    import fbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_DW-1:0] dividend,
    input  wire logic [DIV_VW-1:0] divisor,
    output logic                   done,
    output logic      [DIV_DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_DW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_VW-1:0] dvs_reg;
    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_VW:0]   trial;
    logic [DIV_VW:0]   diff;
    logic              fits;

    // one trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[DIV_DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift into the dividend register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
            quo_reg <= {quo_reg[DIV_DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/frame_budget_controller.sv =====
// ----------------------------------------------------------------------------
// frame_budget_controller
// Frame report in, six per-phase weight results out, with limit control.
// ----------------------------------------------------------------------------
// One frame report is taken while in_stall is low. The block then stalls its
// input until all six results have been taken. The utilisation and the phase
// weights run on one shared 50-step restoring divider and one shared
// multiplier, under a sequencer. The sequencer waits on one divider pass for
// utilisation when the budget is non-zero, and on one for each phase weight
// that is updated; a skipped phase starts no pass. The boost rate is scaled
// by a constant reciprocal multiply, but only when no deadline was missed.
// The input reopens in the cycle after the sixth result.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_budget_controller
    import fbc_pkg::*;
#(
    parameter int FLUSH_PHASE     = 5,
    parameter int PER_PEER_START  = 16,
    parameter int SUBMITTED_START = 64,
    parameter int BOOST_START     = 4294967,
    parameter int WEIGHT_START    = 65536
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [DUR_W-1:0]     dur_phase0,
    input  wire logic [DUR_W-1:0]     dur_phase1,
    input  wire logic [DUR_W-1:0]     dur_phase2,
    input  wire logic [DUR_W-1:0]     dur_phase3,
    input  wire logic [DUR_W-1:0]     dur_phase4,
    input  wire logic [DUR_W-1:0]     dur_phase5,
    input  wire logic [DEF_W-1:0]     deferred_phase0,
    input  wire logic [DEF_W-1:0]     deferred_phase1,
    input  wire logic [DEF_W-1:0]     deferred_phase2,
    input  wire logic [DEF_W-1:0]     deferred_phase3,
    input  wire logic [DEF_W-1:0]     deferred_phase4,
    input  wire logic [DEF_W-1:0]     deferred_phase5,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [IDX_W-1:0]          phase_index,
    output logic [W_W-1:0]            phase_weight,
    output logic                      last,
    output logic [TOT_W-1:0]          tick_duration,
    output logic [USED_W-1:0]         budget_used,
    output logic                      deadline_missed,
    output logic [DEFT_W-1:0]         deferred_total,
    output logic [LIM_W-1:0]          per_peer_limit,
    output logic [LIM_W-1:0]          submitted_limit,
    output logic [BOOST_W-1:0]        boost_rate
);

    // boost scaling: x/10 as (x * ceil(2^33/10)) >> 33, exact for x < 2^30
    localparam int                BNUM_W   = 30;
    localparam int                BPROD_W  = 2 * BNUM_W;
    localparam logic [BNUM_W-1:0] RECIP_10 = 30'd858993460;
    localparam int                RECIP_SH = 33;

    typedef enum logic [3:0] {
        ST_IDLE, ST_USED, ST_UWAIT, ST_WPROD, ST_DPROD, ST_WDIV, ST_WWAIT,
        ST_KPROD, ST_KNOB, ST_BWAIT, ST_OUT
    } state_t;

    // configuration registers
    logic [DUR_W-1:0]  budget_reg;
    logic [TGT_W-1:0]  target_reg;
    logic [TGT_W-1:0]  band_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LIM_W-1:0]  pp_up_reg;
    logic [LIM_W-1:0]  sub_up_reg;

    // state
    state_t            state_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [W_W-1:0]    weight_reg [PHASES];
    logic [DUR_W-1:0]  dur_reg [PHASES];
    logic [LIM_W-1:0]  pp_lim_reg;
    logic [LIM_W-1:0]  sub_lim_reg;
    logic [BOOST_W-1:0] boost_reg;
    logic [LIM_W-1:0]  streak_reg;
    logic [TOT_W-1:0]  tot_reg;
    logic [DEFT_W-1:0] deft_reg;
    logic [SUMW_W-1:0] sumw_reg;
    logic              flush_nz_reg;
    logic [USED_W-1:0] used_reg;
    logic              missed_reg;
    logic [43:0]       wb_reg;
    logic [BNUM_W-1:0] bnum_reg;
    logic [BPROD_W-1:0] bprod_reg;

    // input assembly
    logic [DUR_W-1:0]  in_dur [PHASES];
    logic [DEF_W-1:0]  in_def [PHASES];
    logic [TOT_W-1:0]  tot_sum;
    logic [DEFT_W-1:0] def_sum;
    logic [SUMW_W-1:0] w_sum;
    logic              in_acc;

    // shared units
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] mul_p;
    logic              div_start;
    logic [DIV_DW-1:0] div_dvd;
    logic [DIV_VW-1:0] div_dvs;
    logic              div_done;
    logic [DIV_DW-1:0] div_q;

    // derived terms
    logic              w_skip_all;
    logic              w_skip;
    logic [30:0]       sumw_x10;
    logic [DIV_DW-1:0] w_num;
    logic [DIV_VW-1:0] b_x10;
    logic signed [21:0] err;
    logic signed [21:0] band_s;
    logic              over_band;
    logic              under_band;
    logic [20:0]       mag;
    logic [40:0]       knob_t;
    logic [16:0]       knob_r;
    logic [BNUM_W-1:0] boost_num;
    logic [BOOST_W-1:0] boost_q;
    logic [W_W-1:0]    w_new;

    function automatic logic [LIM_W-1:0] lim_down(input logic [LIM_W-1:0] lim,
                                                  input logic [16:0] r);
        logic [16:0] l17;
        l17 = {1'b0, lim};
        lim_down = (l17 > r) ? LIM_W'(l17 - r) : LIM_W'(1);
    endfunction

    function automatic logic [LIM_W-1:0] lim_up(input logic [LIM_W-1:0] lim,
                                                input logic [16:0] r,
                                                input logic [LIM_W-1:0] upper);
        logic [17:0] s;
        s = {2'b0, lim} + {1'b0, r};
        if (s > {2'b0, upper})
            s = {2'b0, upper};
        if (s == '0)
            s = 18'd1;
        lim_up = s[LIM_W-1:0];
    endfunction

    function automatic logic [LIM_W-1:0] lim_half(input logic [LIM_W-1:0] lim);
        lim_half = (lim > LIM_W'(1)) ? (lim >> 1) : LIM_W'(1);
    endfunction

    assign in_dur = '{dur_phase0, dur_phase1, dur_phase2,
                      dur_phase3, dur_phase4, dur_phase5};
    assign in_def = '{deferred_phase0, deferred_phase1, deferred_phase2,
                      deferred_phase3, deferred_phase4, deferred_phase5};

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // frame sums taken at request time
    always_comb
    begin
        tot_sum = '0;
        def_sum = '0;
        w_sum   = '0;
        for (int i = 0; i < PHASES; i++)
        begin
            tot_sum = tot_sum + TOT_W'(in_dur[i]);
            def_sum = def_sum + DEFT_W'(in_def[i]);
            w_sum   = w_sum + SUMW_W'(weight_reg[i]);
        end
    end

    // weight terms
    assign w_skip_all = (sumw_reg < SUMW_MIN) || (tot_reg < TOT_MIN) || (budget_reg == '0);
    assign sumw_x10   = (31'(sumw_reg) << 3) + (31'(sumw_reg) << 1);
    assign w_skip     = w_skip_all || (wb_reg < 44'(sumw_x10));
    assign w_num      = (DIV_DW'(wb_reg) << 3) + DIV_DW'(wb_reg)
                        + DIV_DW'(mul_p[46:0])
                        + (DIV_DW'(budget_reg) << 2) + DIV_DW'(budget_reg);
    assign b_x10      = (DIV_VW'(budget_reg) << 3) + (DIV_VW'(budget_reg) << 1);
    assign w_new      = (div_q > DIV_DW'(WEIGHT_MAX))   ? WEIGHT_MAX :
                        (div_q < DIV_DW'(WEIGHT_FLOOR)) ? WEIGHT_FLOOR : div_q[W_W-1:0];

    // controller error and knob step
    assign err        = $signed({2'b0, used_reg}) - $signed({5'b0, target_reg});
    assign band_s     = $signed({5'b0, band_reg});
    assign over_band  = (err > band_s);
    assign under_band = (err < -band_s);
    assign mag        = err[21] ? 21'(-err) : 21'(err);
    assign knob_t     = (41'(mul_p[36:0]) << 3) + (41'(mul_p[36:0]) << 1) + 41'(1 << 23);
    assign knob_r     = (knob_t[40:24] == '0) ? 17'd1 : knob_t[40:24];

    // boost rate numerator: up by 1.1 (over 10) or down by 0.95 (over 20)
    assign boost_num  = flush_nz_reg
                        ? (BNUM_W'(boost_reg) << 3) + (BNUM_W'(boost_reg) << 1)
                          + BNUM_W'(boost_reg) + BNUM_W'(5)
                        : (BNUM_W'(boost_reg) << 4) + (BNUM_W'(boost_reg) << 1)
                          + BNUM_W'(boost_reg) + BNUM_W'(10);

    // quotient by 10, or by 20 with one more shift
    assign boost_q    = flush_nz_reg ? BOOST_W'(bprod_reg >> RECIP_SH)
                                     : BOOST_W'(bprod_reg >> (RECIP_SH + 1));

    // shared unit operand selection
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (state_reg)
            ST_USED:
            begin
                div_start = (budget_reg != '0);
                div_dvd   = DIV_DW'({tot_reg, 16'b0});
                div_dvs   = DIV_VW'(budget_reg);
            end
            ST_WPROD:
            begin
                mul_a = MUL_AW'(weight_reg[k_reg]);
                mul_b = MUL_BW'(budget_reg);
            end
            ST_DPROD:
            begin
                mul_a = sumw_reg;
                mul_b = MUL_BW'(dur_reg[k_reg]);
            end
            ST_WDIV:
            begin
                div_start = !w_skip;
                div_dvd   = w_num;
                div_dvs   = b_x10;
            end
            ST_KPROD:
            begin
                mul_a = MUL_AW'(mag);
                mul_b = MUL_BW'(step_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    fbc_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    fbc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= DUR_W'(50000);
            target_reg <= TGT_W'(52429);
            band_reg   <= TGT_W'(3277);
            step_reg   <= STEP_W'(256);
            pp_up_reg  <= LIM_W'(64);
            sub_up_reg <= LIM_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUDGET: budget_reg <= cfg_data;
                REG_TARGET: target_reg <= cfg_data[TGT_W-1:0];
                REG_BAND:   band_reg   <= cfg_data[TGT_W-1:0];
                REG_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
                REG_PP_UP:  pp_up_reg  <= cfg_data[LIM_W-1:0];
                REG_SUB_UP: sub_up_reg <= cfg_data[LIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            pp_lim_reg   <= LIM_W'(PER_PEER_START);
            sub_lim_reg  <= LIM_W'(SUBMITTED_START);
            boost_reg    <= BOOST_W'(BOOST_START);
            streak_reg   <= '0;
            tot_reg      <= '0;
            deft_reg     <= '0;
            sumw_reg     <= '0;
            flush_nz_reg <= 1'b0;
            used_reg     <= '0;
            missed_reg   <= 1'b0;
            wb_reg       <= '0;
            bnum_reg     <= '0;
            bprod_reg    <= '0;
            for (int i = 0; i < PHASES; i++)
            begin
                weight_reg[i] <= W_W'(WEIGHT_START);
                dur_reg[i]    <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        tot_reg      <= tot_sum;
                        deft_reg     <= def_sum;
                        sumw_reg     <= w_sum;
                        flush_nz_reg <= (in_def[FLUSH_PHASE] != '0);
                        for (int i = 0; i < PHASES; i++)
                            dur_reg[i] <= in_dur[i];
                        k_reg        <= '0;
                        state_reg    <= ST_USED;
                    end
                end
                ST_USED:
                begin
                    missed_reg <= (tot_reg > TOT_W'(budget_reg));
                    if (budget_reg == '0)
                    begin
                        used_reg  <= '0;
                        state_reg <= ST_WPROD;
                    end
                    else
                        state_reg <= ST_UWAIT;
                end
                ST_UWAIT:
                begin
                    if (div_done)
                    begin
                        used_reg  <= (div_q > DIV_DW'(USED_MAX)) ? USED_MAX
                                                                  : div_q[USED_W-1:0];
                        state_reg <= ST_WPROD;
                    end
                end
                ST_WPROD:
                begin
                    state_reg <= ST_DPROD;
                end
                ST_DPROD:
                begin
                    wb_reg    <= mul_p[43:0];
                    state_reg <= ST_WDIV;
                end
                ST_WDIV:
                begin
                    if (!w_skip)
                        state_reg <= ST_WWAIT;
                    else if (k_reg == IDX_W'(PHASES - 1))
                        state_reg <= ST_KPROD;
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_WPROD;
                    end
                end
                ST_WWAIT:
                begin
                    if (div_done)
                    begin
                        weight_reg[k_reg] <= w_new;
                        if (k_reg == IDX_W'(PHASES - 1))
                            state_reg <= ST_KPROD;
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_WPROD;
                        end
                    end
                end
                ST_KPROD:
                begin
                    bnum_reg  <= boost_num;
                    state_reg <= ST_KNOB;
                end
                ST_KNOB:
                begin
                    k_reg     <= '0;
                    bprod_reg <= BPROD_W'(bnum_reg) * BPROD_W'(RECIP_10);
                    if (missed_reg)
                    begin
                        if (streak_reg != '1)
                            streak_reg <= streak_reg + 1'b1;
                        pp_lim_reg  <= lim_half(pp_lim_reg);
                        sub_lim_reg <= lim_half(sub_lim_reg);
                        state_reg   <= ST_OUT;
                    end
                    else
                    begin
                        streak_reg <= '0;
                        if (over_band)
                        begin
                            pp_lim_reg  <= lim_down(pp_lim_reg, knob_r);
                            sub_lim_reg <= lim_down(sub_lim_reg, knob_r);
                        end
                        else if (under_band)
                        begin
                            pp_lim_reg  <= lim_up(pp_lim_reg, knob_r, pp_up_reg);
                            sub_lim_reg <= lim_up(sub_lim_reg, knob_r, sub_up_reg);
                        end
                        state_reg <= ST_BWAIT;
                    end
                end
                ST_BWAIT:
                begin
                    if (flush_nz_reg)
                        boost_reg <= (boost_q > BOOST_MAX) ? BOOST_MAX : boost_q;
                    else
                        boost_reg <= (boost_q < BOOST_MIN) ? BOOST_MIN : boost_q;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (k_reg == IDX_W'(PHASES - 1))
                            state_reg <= ST_IDLE;
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result fields
    assign out_valid       = (state_reg == ST_OUT);
    assign phase_index     = k_reg;
    assign phase_weight    = weight_reg[k_reg];
    assign last            = (k_reg == IDX_W'(PHASES - 1));
    assign tick_duration   = tot_reg;
    assign budget_used     = used_reg;
    assign deadline_missed = missed_reg;
    assign deferred_total  = deft_reg;
    assign per_peer_limit  = pp_lim_reg;
    assign submitted_limit = sub_lim_reg;
    assign boost_rate      = boost_reg;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while results pending");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (phase_index == IDX_W'(PHASES - 1)))
        else $error("last flag on wrong phase");

    a_limits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (per_peer_limit != '0 && submitted_limit != '0))
        else $error("chunk limit reached zero");

    a_weight_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WWAIT && div_done) |=> (weight_reg[k_reg] >= WEIGHT_FLOOR ||
                                                 $past(k_reg) != k_reg))
        else $error("weight below floor");

endmodule

`default_nettype wire
